[design/lattice_predator_prey_kmc_step_assert.svh]
// ----------------------------------------------------------------------------
// Lattice predator-prey step: assertion macros
// Shared helpers for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef LATTICE_PREDATOR_PREY_KMC_STEP_ASSERT_SVH
`define LATTICE_PREDATOR_PREY_KMC_STEP_ASSERT_SVH

// Implication in the same cycle, checked outside reset.
`define LPKMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the following cycle, checked outside reset.
`define LPKMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/lpkmc_pkg.sv]
// ----------------------------------------------------------------------------
// Lattice predator-prey step package
// Widths, codes, state encoding and the per-bin weight function.
// ----------------------------------------------------------------------------
package lpkmc_pkg;

  localparam int unsigned MaxSide  = 64;
  localparam int unsigned SideW    = $clog2(MaxSide);
  localparam int unsigned AddrW    = 2 * SideW;
  localparam int unsigned Cells    = MaxSide * MaxSide;
  localparam int unsigned CountW   = $clog2(Cells + 1);
  localparam int unsigned RateW    = 16;
  localparam int unsigned RandW    = 16;
  localparam int unsigned NumBins  = 20;
  localparam int unsigned TotalW   = RateW + $clog2(NumBins);
  localparam int unsigned CfgSideW = 7;

  localparam logic [1:0] SpEmpty = 2'd0;
  localparam logic [1:0] SpPrey  = 2'd1;
  localparam logic [1:0] SpPred  = 2'd2;
  localparam logic [1:0] SpBad   = 2'd3;

  localparam logic [1:0] FuncLoad = 2'd0;
  localparam logic [1:0] FuncRead = 2'd1;
  localparam logic [1:0] FuncStep = 2'd2;

  localparam logic [2:0] KindBirth    = 3'd0;
  localparam logic [2:0] KindPredate  = 3'd1;
  localparam logic [2:0] KindDeath    = 3'd2;
  localparam logic [2:0] KindPreyMove = 3'd3;
  localparam logic [2:0] KindPredMove = 3'd4;

  localparam logic [2:0] RegRows     = 3'd0;
  localparam logic [2:0] RegCols     = 3'd1;
  localparam logic [2:0] RegBirth    = 3'd2;
  localparam logic [2:0] RegPredate  = 3'd3;
  localparam logic [2:0] RegDeath    = 3'd4;
  localparam logic [2:0] RegPreyMove = 3'd5;
  localparam logic [2:0] RegPredMove = 3'd6;
  localparam logic [2:0] RegEdge     = 3'd7;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CELL_A, S_CELL_B, S_DIV, S_SCAN, S_NBR, S_SUM,
    S_MUL, S_SEL, S_WR_SITE, S_WR_NBR, S_RCNT, S_DONE
  } state_e;

  typedef struct packed {
    logic [RateW-1:0] birth;
    logic [RateW-1:0] predate;
    logic [RateW-1:0] death;
    logic [RateW-1:0] prey_move;
    logic [RateW-1:0] pred_move;
  } rates_t;

  function automatic logic [CfgSideW-1:0] eff_side(input logic [CfgSideW-1:0] v);
    logic [CfgSideW-1:0] r;
    r = v;
    if (v == '0) r = CfgSideW'(1);
    else if (v > CfgSideW'(MaxSide)) r = CfgSideW'(MaxSide);
    return r;
  endfunction

  function automatic logic [RateW-1:0] bin_weight(
    input logic [1:0] self_sp,
    input logic [1:0] nb_sp,
    input logic       nb_ok,
    input logic       dir_up,
    input logic [2:0] kind,
    input rates_t     rates
  );
    logic [RateW-1:0] w;
    w = '0;
    case (kind)
      KindBirth:    if (nb_ok && self_sp == SpPrey && nb_sp == SpEmpty) w = rates.birth;
      KindPredate:  if (nb_ok && self_sp == SpPred && nb_sp == SpPrey) w = rates.predate;
      KindDeath:    if (dir_up && self_sp == SpPred) w = rates.death;
      KindPreyMove: if (nb_ok && self_sp == SpPrey && nb_sp == SpEmpty) w = rates.prey_move;
      KindPredMove: if (nb_ok && self_sp == SpPred && nb_sp == SpEmpty) w = rates.pred_move;
      default:      w = '0;
    endcase
    return w;
  endfunction

endpackage

[design/lpkmc_remainder.sv]
// ----------------------------------------------------------------------------
// Lattice predator-prey step: remainder unit
// Restoring division, one quotient bit per cycle; returns pick mod count.
// ----------------------------------------------------------------------------
module lpkmc_remainder import lpkmc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RandW-1:0]  dividend_i,
  input  logic [CountW-1:0] divisor_i,
  output logic              done_o,
  output logic [CountW-1:0] rem_o
);

  localparam int unsigned StepW = $clog2(RandW + 1);

  logic [StepW-1:0]  step_q, step_d;
  logic              busy_q, busy_d;
  logic [RandW-1:0]  dvd_q, dvd_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [CountW-1:0] dsr_q, dsr_d;
  logic [CountW:0]   shifted;

  assign shifted = {rem_q, dvd_q[RandW-1]};

  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[RandW-2:0], 1'b0};
      if (shifted >= {1'b0, dsr_q}) rem_d = CountW'(shifted - {1'b0, dsr_q});
      else rem_d = CountW'(shifted);
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(RandW - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = busy_q && (step_q == StepW'(RandW - 1));
  assign rem_o  = rem_d;

endmodule

[design/lattice_predator_prey_kmc_step.sv]
// ----------------------------------------------------------------------------
// Lattice predator-prey kinetic Monte Carlo step
// Lattice in one synchronous RAM; load, read and reaction-step transactions.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// s_axis   in         tuser: func; tdata: row, column, species, pick, draw
// m_axis   out        tuser: reaction_kind; tdata: species .. occupied_total
// apb      in/out     eight 32-bit registers at byte addresses 4*i
//
// After reset the lattice RAM is cleared one cell a cycle.
// Load and read pass through two cell states; a step runs the remainder unit,
// the rank scan (one RAM read a cycle), neighbour reads, bin sum, multiply,
// bin select and the site writes. A write to row_count or column_count recounts.
// A waiting result does not block acceptance; completion waits for the
// output register to drain.
module lattice_predator_prey_kmc_step import lpkmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: cell_row, cell_column, species_in, pick_random, draw_random
  input  logic [47:0] s_axis_tdata,
  // tuser: func
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: species_out, reacted, reaction_direction, site_row, site_column,
  //        occupied_total
  output logic [31:0] m_axis_tdata,
  // tuser: reaction_kind
  output logic [2:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_e state_q, state_d;

  logic [CfgSideW-1:0] rows_q, cols_q;
  rates_t              rates_q;
  logic                edge_q;
  logic [CfgSideW-1:0] eff_r, eff_c;

  logic [1:0]       mem [Cells];
  logic [1:0]       rd_q;
  logic [AddrW-1:0] raddr, waddr;
  logic             we;
  logic [1:0]       wdata;

  logic [AddrW-1:0]  clr_q;
  logic [CountW-1:0] occ_q;

  logic [1:0]       func_q, sp_q;
  logic [SideW-1:0] cr_q, cc_q;
  logic [RandW-1:0] draw_q;
  logic [SideW-1:0] in_r, in_c;
  logic [1:0]       in_func, in_sp;
  logic             in_acc, in_area;

  logic [1:0]       res_sp_q;
  logic             res_react_q;
  logic [2:0]       res_kind_q;
  logic [1:0]       res_dir_q;
  logic [SideW-1:0] res_r_q, res_c_q;

  logic              ov_q;
  logic [31:0]       otd_q;
  logic [2:0]        otu_q;
  logic              out_load;

  logic              cfg_we, cfg_rc_wr;
  logic [2:0]        cfg_idx;

  logic              div_start, div_done;
  logic [CountW-1:0] div_rem, rank_q;

  logic [SideW-1:0]  sc_r_q, sc_c_q, pr_q, pc_q;
  logic              issue_q, pv_q, scan_init, scan_last, found;
  logic [CountW-1:0] seen_q, cnt_q;

  logic [SideW-1:0] nb_r [4];
  logic [SideW-1:0] nb_c [4];
  logic [3:0]       nb_ok;
  logic [1:0]       nb_sp_q [4];
  logic [2:0]       nb_i_q;
  logic [1:0]       nb_prev;

  logic [1:0]        bd_q;
  logic [2:0]        bk_q;
  logic              last_bin;
  logic [RateW-1:0]  w;
  logic [TotalW-1:0] acc_q, acc_next, target_q;
  logic [TotalW:0]   bin_end;
  logic              hit;

  assign eff_r   = eff_side(rows_q);
  assign eff_c   = eff_side(cols_q);
  assign in_r    = s_axis_tdata[5:0];
  assign in_c    = s_axis_tdata[11:6];
  assign in_sp   = s_axis_tdata[13:12];
  assign in_func = s_axis_tuser;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_area = ({1'b0, in_r} < eff_r) && ({1'b0, in_c} < eff_c);

  assign pready    = 1'b1;
  assign cfg_we    = psel && penable && pwrite;
  assign cfg_idx   = paddr[4:2];
  assign cfg_rc_wr = cfg_we && (cfg_idx == RegRows || cfg_idx == RegCols);

  always_comb begin
    case (cfg_idx)
      RegRows:     prdata = 32'(rows_q);
      RegCols:     prdata = 32'(cols_q);
      RegBirth:    prdata = 32'(rates_q.birth);
      RegPredate:  prdata = 32'(rates_q.predate);
      RegDeath:    prdata = 32'(rates_q.death);
      RegPreyMove: prdata = 32'(rates_q.prey_move);
      RegPredMove: prdata = 32'(rates_q.pred_move);
      default:     prdata = 32'(edge_q);
    endcase
  end

  // Neighbours of the chosen site.
  always_comb begin
    logic [CfgSideW-1:0] r1, c1;
    r1 = eff_r - CfgSideW'(1);
    c1 = eff_c - CfgSideW'(1);
    for (int d = 0; d < 4; d++) begin
      nb_r[d]  = res_r_q;
      nb_c[d]  = res_c_q;
      nb_ok[d] = 1'b1;
    end
    if (res_r_q == '0) begin
      nb_r[0] = r1[SideW-1:0];
      nb_ok[0] = !edge_q;
    end else nb_r[0] = res_r_q - SideW'(1);
    if ({1'b0, res_r_q} >= r1) begin
      nb_r[1] = '0;
      nb_ok[1] = !edge_q;
    end else nb_r[1] = res_r_q + SideW'(1);
    if (res_c_q == '0) begin
      nb_c[2] = c1[SideW-1:0];
      nb_ok[2] = !edge_q;
    end else nb_c[2] = res_c_q - SideW'(1);
    if ({1'b0, res_c_q} >= c1) begin
      nb_c[3] = '0;
      nb_ok[3] = !edge_q;
    end else nb_c[3] = res_c_q + SideW'(1);
  end

  assign nb_prev   = 2'(nb_i_q - 3'd1);
  assign scan_last = ({1'b0, sc_r_q} == eff_r - CfgSideW'(1)) &&
                     ({1'b0, sc_c_q} == eff_c - CfgSideW'(1));
  assign found     = pv_q && (rd_q != SpEmpty) && (seen_q == rank_q);
  assign last_bin  = (bd_q == 2'd3) && (bk_q == KindPredMove);
  assign w         = bin_weight(res_sp_q, nb_sp_q[bd_q], nb_ok[bd_q], bd_q == 2'd0,
                                bk_q, rates_q);
  assign acc_next  = acc_q + TotalW'(w);
  assign bin_end   = {1'b0, acc_q} + (TotalW + 1)'(w);
  assign hit       = (w != '0) && (target_q >= acc_q) && ({1'b0, target_q} < bin_end);
  assign out_load  = (state_q == S_DONE) && (!ov_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == AddrW'(Cells - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          if ((in_func == FuncLoad || in_func == FuncRead) && in_area) state_d = S_CELL_A;
          else if (in_func == FuncStep && occ_q != '0) state_d = S_DIV;
          else state_d = S_DONE;
        end
      end
      S_CELL_A:  state_d = S_CELL_B;
      S_CELL_B:  state_d = S_DONE;
      S_DIV:     if (div_done) state_d = S_SCAN;
      S_SCAN:    if (found) state_d = S_NBR;
      S_NBR:     if (nb_i_q == 3'd4) state_d = S_SUM;
      S_SUM:     if (last_bin) state_d = (acc_next == '0) ? S_DONE : S_MUL;
      S_MUL:     state_d = S_SEL;
      S_SEL:     if (hit || last_bin) state_d = S_WR_SITE;
      S_WR_SITE: state_d = S_WR_NBR;
      S_WR_NBR:  state_d = S_DONE;
      S_RCNT:    if (pv_q && !issue_q) state_d = S_IDLE;
      S_DONE:    if (out_load) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
    if (cfg_rc_wr && state_q != S_CLEAR) state_d = S_RCNT;
  end

  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    div_start     = (state_q == S_IDLE) && (state_d == S_DIV);
    scan_init     = ((state_d == S_SCAN) && (state_q != S_SCAN)) ||
                    ((state_d == S_RCNT) && ((state_q != S_RCNT) || cfg_rc_wr));
    raddr = {sc_r_q, sc_c_q};
    waddr = {res_r_q, res_c_q};
    we    = 1'b0;
    wdata = SpEmpty;
    case (state_q)
      S_CLEAR: begin
        waddr = clr_q;
        we    = 1'b1;
      end
      S_CELL_A: raddr = {cr_q, cc_q};
      S_CELL_B: begin
        waddr = {cr_q, cc_q};
        wdata = sp_q;
        we    = (func_q == FuncLoad) && (sp_q != SpBad);
      end
      S_NBR: raddr = {nb_r[nb_i_q[1:0]], nb_c[nb_i_q[1:0]]};
      S_WR_SITE: we = (res_kind_q == KindDeath) || (res_kind_q == KindPreyMove) ||
                      (res_kind_q == KindPredMove);
      S_WR_NBR: begin
        waddr = {nb_r[res_dir_q], nb_c[res_dir_q]};
        wdata = (res_kind_q == KindBirth || res_kind_q == KindPreyMove) ? SpPrey : SpPred;
        we    = (res_kind_q != KindDeath);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  lpkmc_remainder u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (s_axis_tdata[29:14]),
    .divisor_i  (occ_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      occ_q   <= '0;
      ov_q    <= 1'b0;
      issue_q <= 1'b0;
      pv_q    <= 1'b0;
      rows_q  <= CfgSideW'(MaxSide);
      cols_q  <= CfgSideW'(MaxSide);
      rates_q <= '{birth: RateW'(256), predate: RateW'(256), death: RateW'(256),
                   prey_move: '0, pred_move: '0};
      edge_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + AddrW'(1);
      if (cfg_we) begin
        case (cfg_idx)
          RegRows:     rows_q            <= pwdata[CfgSideW-1:0];
          RegCols:     cols_q            <= pwdata[CfgSideW-1:0];
          RegBirth:    rates_q.birth     <= pwdata[RateW-1:0];
          RegPredate:  rates_q.predate   <= pwdata[RateW-1:0];
          RegDeath:    rates_q.death     <= pwdata[RateW-1:0];
          RegPreyMove: rates_q.prey_move <= pwdata[RateW-1:0];
          RegPredMove: rates_q.pred_move <= pwdata[RateW-1:0];
          default:     edge_q            <= pwdata[0];
        endcase
      end
      if (out_load) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
      if (scan_init) begin
        issue_q <= 1'b1;
        pv_q    <= 1'b0;
      end else if (state_q == S_SCAN || state_q == S_RCNT) begin
        pv_q <= issue_q;
        if (scan_last) issue_q <= 1'b0;
      end
      if (state_q == S_CELL_B && we) begin
        occ_q <= occ_q - CountW'(rd_q != SpEmpty) + CountW'(sp_q != SpEmpty);
      end
      if (state_q == S_WR_NBR) begin
        if (res_kind_q == KindBirth) occ_q <= occ_q + CountW'(1);
        else if (res_kind_q == KindDeath) occ_q <= occ_q - CountW'(1);
      end
      if (state_q == S_RCNT && pv_q && !issue_q && !cfg_rc_wr) begin
        occ_q <= cnt_q + CountW'(rd_q != SpEmpty);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q      <= in_func;
      cr_q        <= in_r;
      cc_q        <= in_c;
      sp_q        <= in_sp;
      draw_q      <= s_axis_tdata[45:30];
      res_sp_q    <= SpEmpty;
      res_react_q <= 1'b0;
      res_kind_q  <= KindBirth;
      res_dir_q   <= 2'd0;
      res_r_q     <= '0;
      res_c_q     <= '0;
    end
    if (state_q == S_CELL_B) res_sp_q <= we ? sp_q : rd_q;
    if (div_done) rank_q <= div_rem;
    if (scan_init) begin
      sc_r_q <= '0;
      sc_c_q <= '0;
      seen_q <= '0;
      cnt_q  <= '0;
    end else if (state_q == S_SCAN || state_q == S_RCNT) begin
      if (issue_q) begin
        pr_q <= sc_r_q;
        pc_q <= sc_c_q;
        if ({1'b0, sc_c_q} == eff_c - CfgSideW'(1)) begin
          sc_c_q <= '0;
          sc_r_q <= sc_r_q + SideW'(1);
        end else sc_c_q <= sc_c_q + SideW'(1);
      end
      if (pv_q && rd_q != SpEmpty) begin
        seen_q <= seen_q + CountW'(1);
        cnt_q  <= cnt_q + CountW'(1);
      end
    end
    if (state_q == S_SCAN && found) begin
      res_r_q  <= pr_q;
      res_c_q  <= pc_q;
      res_sp_q <= rd_q;
      nb_i_q   <= '0;
    end
    if (state_q == S_NBR) begin
      nb_i_q <= nb_i_q + 3'd1;
      if (nb_i_q != 3'd0) nb_sp_q[nb_prev] <= nb_ok[nb_prev] ? rd_q : SpEmpty;
      if (nb_i_q == 3'd4) begin
        acc_q <= '0;
        bd_q  <= 2'd0;
        bk_q  <= KindBirth;
      end
    end
    if (state_q == S_SUM || (state_q == S_SEL && !hit)) begin
      acc_q <= acc_next;
      if (bk_q == KindPredMove) begin
        bk_q <= KindBirth;
        bd_q <= bd_q + 2'd1;
      end else bk_q <= bk_q + 3'd1;
    end
    if (state_q == S_MUL) begin
      target_q <= TotalW'(({{RandW{1'b0}}, acc_q} * {{TotalW{1'b0}}, draw_q}) >> RandW);
      acc_q    <= '0;
      bd_q     <= 2'd0;
      bk_q     <= KindBirth;
    end
    if (state_q == S_SEL && (hit || last_bin)) begin
      res_react_q <= 1'b1;
      res_kind_q  <= bk_q;
      res_dir_q   <= bd_q;
    end
    if (out_load) begin
      otd_q <= {2'b00, occ_q, res_c_q, res_r_q, res_dir_q, res_react_q, res_sp_q};
      otu_q <= res_kind_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = otd_q;
  assign m_axis_tuser  = otu_q;

  `include "lattice_predator_prey_kmc_step_assert.svh"

  `LPKMC_ASSERT_IMP(a_no_accept_in_clear, state_q == S_CLEAR, !s_axis_tready,
                    "input accepted during the clearing pass")
  `LPKMC_ASSERT_IMP(a_occ_bound, 1'b1, occ_q <= CountW'(Cells),
                    "occupied count exceeds the lattice size")
  `LPKMC_ASSERT_IMP(a_rank_below_count, state_q == S_SCAN, rank_q < occ_q,
                    "rank is not below the occupied count")
  `LPKMC_ASSERT_NXT(a_done_loads_output, out_load, m_axis_tvalid,
                    "completed transaction did not reach the output register")

endmodule
